// ===== rtl/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, register indexes, reset values and helpers for the pulsar
// trigger masking block.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int unsigned VOICES_DEF = 16;
  localparam int unsigned BUSY_W     = 16;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned PAN_W      = 17;
  localparam int unsigned PAN_SUM_W  = 20;   // signed, holds the unclamped pan sum

  localparam logic [PAN_W-1:0] Q16_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BURST_SETTING   = 3'd0,
    REG_CHANNEL_SETTING = 3'd1,
    REG_CHANNEL_MODE    = 3'd2,
    REG_KEEP_PROB       = 3'd3,
    REG_PAN_POSITION    = 3'd4,
    REG_PAN_SPREAD      = 3'd5,
    REG_CHANNEL_OFFSET  = 3'd6,
    REG_AMPLITUDE       = 3'd7
  } reg_idx_e;

  // Channel counting modes; codes 2 and 3 both count completed burst cycles while bursting is enabled
  localparam logic [1:0] MODE_EVERY    = 2'd0;
  localparam logic [1:0] MODE_UNMASKED = 2'd1;

  localparam logic [16:0] BURST_SETTING_RST   = 17'd4104;
  localparam logic [16:0] CHANNEL_SETTING_RST = 17'd4104;
  localparam logic [1:0]  CHANNEL_MODE_RST    = 2'd1;
  localparam logic [16:0] KEEP_PROB_RST       = 17'd65536;
  localparam logic [16:0] PAN_POSITION_RST    = 17'd32768;
  localparam logic [15:0] PAN_SPREAD_RST      = 16'd0;
  localparam logic [15:0] CHANNEL_OFFSET_RST  = 16'd16384;
  localparam logic [15:0] AMPLITUDE_RST       = 16'd65535;

  typedef struct packed {
    logic [16:0] burst_setting;
    logic [16:0] channel_setting;
    logic [1:0]  channel_mode;
    logic [16:0] keep_prob;
    logic [16:0] pan_position;
    logic [15:0] pan_spread;
    logic [15:0] channel_offset;
    logic [15:0] amplitude;
  } cfg_t;

  typedef struct packed {
    logic             burst_en;
    logic             chance_en;
    logic             channel_en;
    logic [CNT_W-1:0] burst_cnt;
    logic [CNT_W-1:0] channel_cnt;
  } state_t;

  typedef struct packed {
    logic             fire;
    logic [3:0]       voice_index;
    logic [PAN_W-1:0] pan;
    logic [15:0]      amplitude;
    logic             burst_masked;
    logic             chance_masked;
    logic             no_free_voice;
  } result_t;

  // Counter step: increment, fall back to zero once the total is reached
  function automatic logic [CNT_W-1:0] wrap_count(logic [CNT_W-1:0] count,
                                                  logic [CNT_W-1:0] total);
    logic [CNT_W:0] nxt;
    nxt = {1'b0, count} + {{CNT_W{1'b0}}, 1'b1};
    if (nxt >= {1'b0, total}) begin
      return '0;
    end
    return nxt[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/ptm_step.sv =====
// ----------------------------------------------------------------------------
// ptm_step
// Combinational evaluation of one trigger: burst, channel and stochastic
// masking, free voice search and pan arithmetic, plus next counter values.
// ----------------------------------------------------------------------------
module ptm_step
  import ptm_pkg::*;
#(
  parameter int unsigned VOICES = VOICES_DEF
) (
  input  cfg_t              cfg_i,
  input  state_t            state_i,
  input  logic [BUSY_W-1:0] voice_busy_i,
  input  logic [15:0]       chance_sample_i,
  input  logic [15:0]       spread_sample_i,
  output result_t           result_o,
  output logic [CNT_W-1:0]  burst_cnt_o,
  output logic [CNT_W-1:0]  channel_cnt_o
);

  // voice_busy only shows the low voices
  localparam int unsigned SEARCH = (VOICES < BUSY_W) ? VOICES : BUSY_W;

  logic             off_part;
  logic [CNT_W-1:0] burst_wrap;
  logic             bmask;
  logic             cycle_mode;
  logic             adv_channel;
  logic [CNT_W-1:0] ch_next;
  logic             cmask;
  logic             found;
  logic [3:0]       voice;
  logic             left;
  logic [31:0]      prod;
  logic [16:0]      scaled;
  logic signed [PAN_SUM_W-1:0] pan_sum;
  logic [PAN_W-1:0] pan_clamped;

  always_comb begin
    off_part   = state_i.burst_cnt >= cfg_i.burst_setting[7:0];
    burst_wrap = wrap_count(state_i.burst_cnt, cfg_i.burst_setting[15:8]);
    bmask      = state_i.burst_en && (cfg_i.burst_setting[16] ? !off_part : off_part);
    cycle_mode = state_i.burst_en && (cfg_i.channel_mode != MODE_EVERY) &&
                 (cfg_i.channel_mode != MODE_UNMASKED);
    adv_channel = (cycle_mode && (burst_wrap == '0)) ||
                  (cfg_i.channel_mode == MODE_EVERY) ||
                  (!cycle_mode && !bmask);
    ch_next = adv_channel ? wrap_count(state_i.channel_cnt, cfg_i.channel_setting[15:8])
                          : state_i.channel_cnt;
    burst_cnt_o   = state_i.burst_en ? burst_wrap : state_i.burst_cnt;
    channel_cnt_o = ch_next;

    cmask = !bmask && state_i.chance_en && (cfg_i.keep_prob < {1'b0, chance_sample_i});
  end

  // lowest free voice: scan from the top so the lowest index wins
  always_comb begin
    found = 1'b0;
    voice = '0;
    for (int i = SEARCH - 1; i >= 0; i--) begin
      if (!voice_busy_i[i]) begin
        found = 1'b1;
        voice = 4'(i);
      end
    end
  end

  always_comb begin
    left = (ch_next < cfg_i.channel_setting[7:0]) ^ cfg_i.channel_setting[16];
    // 2*spread*sample >> 16
    prod   = cfg_i.pan_spread * spread_sample_i;
    scaled = prod[31:15];
    pan_sum = $signed({3'b000, cfg_i.pan_position})
            + $signed({3'b000, scaled})
            - $signed({4'b0000, cfg_i.pan_spread});
    if (state_i.channel_en) begin
      if (left) begin
        pan_sum = pan_sum - $signed({4'b0000, cfg_i.channel_offset});
      end else begin
        pan_sum = pan_sum + $signed({4'b0000, cfg_i.channel_offset});
      end
    end
    if (pan_sum < 0) begin
      pan_clamped = '0;
    end else if (pan_sum > $signed({3'b000, Q16_ONE})) begin
      pan_clamped = Q16_ONE;
    end else begin
      pan_clamped = pan_sum[PAN_W-1:0];
    end
  end

  always_comb begin
    result_o               = '0;
    result_o.burst_masked  = bmask;
    result_o.chance_masked = cmask;
    if (!bmask && !cmask) begin
      if (found) begin
        result_o.fire        = 1'b1;
        result_o.voice_index = voice;
        result_o.pan         = pan_clamped;
        result_o.amplitude   = cfg_i.amplitude;
      end else begin
        result_o.no_free_voice = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pulsar_trigger_masking.sv =====
// ----------------------------------------------------------------------------
// pulsar_trigger_masking
// Trigger masking front end: input register, single-pass evaluation, result
// register. An accepted trigger moves from the input register into the result
// register, raising result valid, once that register is empty or being taken.
// Throughput is one trigger per cycle while results are taken; the input stage
// advances whenever the result register is empty or being taken. Reset clears
// stage valids, counters and masking enables and loads register defaults.
// ----------------------------------------------------------------------------
module pulsar_trigger_masking
  import ptm_pkg::*;
#(
  parameter int unsigned VOICES = VOICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BUSY_W-1:0]    voice_busy_i,
  input  logic [15:0]          chance_sample_i,
  input  logic [15:0]          spread_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 fire_o,
  output logic [3:0]           voice_index_o,
  output logic [PAN_W-1:0]     pan_out_o,
  output logic [15:0]          amplitude_out_o,
  output logic                 burst_masked_o,
  output logic                 chance_masked_o,
  output logic                 no_free_voice_o
);

  cfg_t              cfg_q;
  state_t            state_q;
  logic              s1_valid_q;
  logic [BUSY_W-1:0] busy_q;
  logic [15:0]       chance_q;
  logic [15:0]       spread_q;
  logic              out_valid_q;
  result_t           out_q;

  result_t           result_d;
  logic [CNT_W-1:0]  burst_cnt_d;
  logic [CNT_W-1:0]  channel_cnt_d;
  logic              s1_adv;
  logic              in_xfer;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  ptm_step #(
    .VOICES(VOICES)
  ) u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .voice_busy_i   (busy_q),
    .chance_sample_i(chance_q),
    .spread_sample_i(spread_q),
    .result_o       (result_d),
    .burst_cnt_o    (burst_cnt_d),
    .channel_cnt_o  (channel_cnt_d)
  );

  // configuration registers and masking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.burst_setting   <= BURST_SETTING_RST;
      cfg_q.channel_setting <= CHANNEL_SETTING_RST;
      cfg_q.channel_mode    <= CHANNEL_MODE_RST;
      cfg_q.keep_prob       <= KEEP_PROB_RST;
      cfg_q.pan_position    <= PAN_POSITION_RST;
      cfg_q.pan_spread      <= PAN_SPREAD_RST;
      cfg_q.channel_offset  <= CHANNEL_OFFSET_RST;
      cfg_q.amplitude       <= AMPLITUDE_RST;
      state_q               <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BURST_SETTING: begin
          cfg_q.burst_setting <= cfg_data_i;
          state_q.burst_en    <= 1'b1;
          state_q.burst_cnt   <= '0;
        end
        REG_CHANNEL_SETTING: begin
          cfg_q.channel_setting <= cfg_data_i;
          state_q.channel_en    <= 1'b1;
          state_q.channel_cnt   <= '0;
        end
        REG_CHANNEL_MODE: cfg_q.channel_mode <= cfg_data_i[1:0];
        REG_KEEP_PROB: begin
          cfg_q.keep_prob   <= cfg_data_i;
          state_q.chance_en <= 1'b1;
        end
        REG_PAN_POSITION:   cfg_q.pan_position   <= cfg_data_i;
        REG_PAN_SPREAD:     cfg_q.pan_spread     <= cfg_data_i[15:0];
        REG_CHANNEL_OFFSET: cfg_q.channel_offset <= cfg_data_i[15:0];
        REG_AMPLITUDE:      cfg_q.amplitude      <= cfg_data_i[15:0];
        default: ;
      endcase
    end else if (s1_valid_q && s1_adv) begin
      state_q.burst_cnt   <= burst_cnt_d;
      state_q.channel_cnt <= channel_cnt_d;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      busy_q   <= voice_busy_i;
      chance_q <= chance_sample_i;
      spread_q <= spread_sample_i;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fire_o          = out_q.fire;
  assign voice_index_o   = out_q.voice_index;
  assign pan_out_o       = out_q.pan;
  assign amplitude_out_o = out_q.amplitude;
  assign burst_masked_o  = out_q.burst_masked;
  assign chance_masked_o = out_q.chance_masked;
  assign no_free_voice_o = out_q.no_free_voice;

endmodule
